@@ sv/fta_pkg.sv @@
// ----------------------------------------------------------------------------
// Fixed-timestep accumulator package
// Shared widths, operation codes, register indexes and state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fta_pkg;

  localparam int unsigned ELAPSED_W    = 32;
  localparam int unsigned SCALE_W      = 16;
  localparam int unsigned PROD_W       = ELAPSED_W + SCALE_W;
  localparam int unsigned WIDE_W       = 40;
  localparam int unsigned REM_W        = 32;
  localparam int unsigned SUM_W        = 41;
  localparam int unsigned RATE_W       = 16;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned FRAC_BITS_DF = 8;

  localparam logic [1:0] OP_FRAME  = 2'd0;
  localparam logic [1:0] OP_RESYNC = 2'd1;
  localparam logic [1:0] OP_COPY   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIXED_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_FRAME = 2'd2;

  localparam logic [ELAPSED_W-1:0] FIXED_STEP_RST   = 32'd16666667;
  localparam logic [SCALE_W-1:0]   TIME_SCALE_RST   = 16'd256;
  localparam logic [ELAPSED_W-1:0] TARGET_FRAME_RST = 32'd16666666;
  localparam logic [SUM_W-1:0]     NS_PER_SECOND    = 41'd1000000000;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(SCALE_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SUM_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } fta_state_e;

endpackage

`default_nettype wire

@@ sv/fta_if.sv @@
// ----------------------------------------------------------------------------
// Fixed-timestep accumulator channels
// Valid/ready interfaces for the input words and the result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fta_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     operation;
  logic [fta_pkg::ELAPSED_W-1:0]  elapsed_ns;

  modport source (output valid, output operation, output elapsed_ns, input ready);
  modport sink (input valid, input operation, input elapsed_ns, output ready);
endinterface

interface fta_out_if;
  logic                           valid;
  logic                           ready;
  logic [fta_pkg::ELAPSED_W-1:0]  real_delta_ns;
  logic [fta_pkg::WIDE_W-1:0]     scaled_delta_ns;
  logic [fta_pkg::WIDE_W-1:0]     fixed_delta_ns;
  logic [fta_pkg::WIDE_W-1:0]     scaled_steps;
  logic [fta_pkg::ELAPSED_W-1:0]  real_steps;
  logic [fta_pkg::RATE_W-1:0]     frame_rate;

  modport source (
    output valid, output real_delta_ns, output scaled_delta_ns, output fixed_delta_ns,
    output scaled_steps, output real_steps, output frame_rate, input ready
  );
  modport sink (
    input valid, input real_delta_ns, input scaled_delta_ns, input fixed_delta_ns,
    input scaled_steps, input real_steps, input frame_rate, output ready
  );
endinterface

`default_nettype wire

@@ sv/fixed_timestep_accumulator_unit.sv @@
// Sequence: a frame word accepted in idle runs 16 multiply steps, a load state,
// 41 divide steps and a finish state, which waits while the output register is
// still occupied. A resync or copy word updates the remainders when accepted.
// No new word is accepted until a frame word has left the finish state.
// Reset clears the accumulators, arms the first-frame flag and loads register defaults.
// ----------------------------------------------------------------------------
// Fixed-timestep accumulator unit
// Scales frame time, computes the frame rate and tracks whole fixed steps
// on a scaled and a real remainder accumulator using serial arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_timestep_accumulator_unit #(
  parameter int unsigned SCALE_FRAC_BITS = fta_pkg::FRAC_BITS_DF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [fta_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [fta_pkg::ELAPSED_W-1:0]     cfg_wdata_i,
  fta_in_if.sink                                 in_i,
  fta_out_if.source                              out_o
);

  fta_pkg::fta_state_e state_q, state_d;
  logic [fta_pkg::CNT_W-1:0] cnt_q, cnt_d;

  logic [fta_pkg::ELAPSED_W-1:0] fixed_step_q;
  logic [fta_pkg::SCALE_W-1:0]   time_scale_q;
  logic [fta_pkg::ELAPSED_W-1:0] target_frame_q;
  logic                          first_q;

  logic [fta_pkg::REM_W-1:0] rem_s_q, rem_r_q;

  logic [fta_pkg::ELAPSED_W-1:0] elapsed_q;
  logic                          var_q;
  logic                          first_item_q;
  logic [fta_pkg::PROD_W-1:0]    prod_q;
  logic [fta_pkg::ELAPSED_W:0]   prod_hi;
  logic [fta_pkg::PROD_W-1:0]    prod_shr;
  logic [fta_pkg::WIDE_W-1:0]    scaled;

  logic accept, frame_acc, mul_step, div_load, div_step, done_fire, upd;

  logic [fta_pkg::WIDE_W-1:0]    qs;
  logic [fta_pkg::ELAPSED_W-1:0] qr;
  logic [fta_pkg::RATE_W-1:0]    qf;
  logic [fta_pkg::REM_W-1:0]     rs, rr, rf;

  logic                           out_valid_q;
  logic [fta_pkg::ELAPSED_W-1:0]  o_real_delta_q;
  logic [fta_pkg::WIDE_W-1:0]     o_scaled_delta_q;
  logic [fta_pkg::WIDE_W-1:0]     o_fixed_delta_q;
  logic [fta_pkg::WIDE_W-1:0]     o_scaled_steps_q;
  logic [fta_pkg::ELAPSED_W-1:0]  o_real_steps_q;
  logic [fta_pkg::RATE_W-1:0]     o_frame_rate_q;

  assign accept    = in_i.valid && in_i.ready;
  assign frame_acc = accept && (in_i.operation == fta_pkg::OP_FRAME);
  assign upd       = !var_q && !first_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fta_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_i.ready = 1'b0;
    mul_step   = 1'b0;
    div_load   = 1'b0;
    div_step   = 1'b0;
    done_fire  = 1'b0;
    unique case (state_q)
      fta_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid && in_i.operation == fta_pkg::OP_FRAME) begin
          state_d = fta_pkg::ST_MUL;
          cnt_d   = fta_pkg::MUL_LAST;
        end
      end
      fta_pkg::ST_MUL: begin
        mul_step = 1'b1;
        cnt_d    = cnt_q - fta_pkg::CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = fta_pkg::ST_LOAD;
        end
      end
      fta_pkg::ST_LOAD: begin
        div_load = 1'b1;
        state_d  = fta_pkg::ST_DIV;
        cnt_d    = fta_pkg::DIV_LAST;
      end
      fta_pkg::ST_DIV: begin
        div_step = 1'b1;
        cnt_d    = cnt_q - fta_pkg::CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = fta_pkg::ST_DONE;
        end
      end
      fta_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          done_fire = 1'b1;
          state_d   = fta_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fta_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_step_q   <= fta_pkg::FIXED_STEP_RST;
      time_scale_q   <= fta_pkg::TIME_SCALE_RST;
      target_frame_q <= fta_pkg::TARGET_FRAME_RST;
      first_q        <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fta_pkg::REG_FIXED_STEP: begin
            fixed_step_q <= cfg_wdata_i;
            if (cfg_wdata_i == '0) begin
              first_q <= 1'b0;
            end
          end
          fta_pkg::REG_TIME_SCALE: begin
            time_scale_q <= cfg_wdata_i[fta_pkg::SCALE_W-1:0];
          end
          fta_pkg::REG_TARGET_FRAME: begin
            target_frame_q <= cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end
      if (frame_acc) begin
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_s_q <= '0;
      rem_r_q <= '0;
    end else if (accept && in_i.operation == fta_pkg::OP_RESYNC) begin
      rem_s_q <= {1'b0, target_frame_q[fta_pkg::ELAPSED_W-1:1]};
      rem_r_q <= {1'b0, target_frame_q[fta_pkg::ELAPSED_W-1:1]};
    end else if (accept && in_i.operation == fta_pkg::OP_COPY) begin
      rem_r_q <= rem_s_q;
    end else if (done_fire && upd) begin
      rem_s_q <= rs;
      rem_r_q <= rr;
    end
  end

  assign prod_hi  = {1'b0, prod_q[fta_pkg::PROD_W-1:fta_pkg::SCALE_W]}
                  + (prod_q[0] ? {1'b0, elapsed_q} : '0);
  assign prod_shr = prod_q >> SCALE_FRAC_BITS;
  assign scaled   = (|prod_shr[fta_pkg::PROD_W-1:fta_pkg::WIDE_W]) ? '1
                  : prod_shr[fta_pkg::WIDE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (frame_acc) begin
      elapsed_q    <= in_i.elapsed_ns;
      var_q        <= (fixed_step_q == '0);
      first_item_q <= first_q;
      prod_q       <= {{fta_pkg::ELAPSED_W{1'b0}}, time_scale_q};
    end else if (mul_step) begin
      prod_q <= {prod_hi, prod_q[fta_pkg::SCALE_W-1:1]};
    end
  end

  fta_div #(.QUOT_W(fta_pkg::WIDE_W)) u_div_scaled (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (div_step),
    .dividend_i ({9'd0, rem_s_q} + {1'b0, scaled}),
    .divisor_i  (fixed_step_q),
    .quot_o     (qs),
    .rem_o      (rs)
  );

  fta_div #(.QUOT_W(fta_pkg::ELAPSED_W)) u_div_real (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (div_step),
    .dividend_i ({9'd0, rem_r_q} + {9'd0, elapsed_q}),
    .divisor_i  (fixed_step_q),
    .quot_o     (qr),
    .rem_o      (rr)
  );

  fta_div #(.QUOT_W(fta_pkg::RATE_W)) u_div_rate (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (div_step),
    .dividend_i (fta_pkg::NS_PER_SECOND),
    .divisor_i  (elapsed_q),
    .quot_o     (qf),
    .rem_o      (rf)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      o_real_delta_q   <= elapsed_q;
      o_scaled_delta_q <= scaled;
      o_frame_rate_q   <= qf;
      if (var_q) begin
        o_fixed_delta_q  <= scaled;
        o_scaled_steps_q <= fta_pkg::WIDE_W'(1);
        o_real_steps_q   <= fta_pkg::ELAPSED_W'(1);
      end else if (first_item_q) begin
        o_fixed_delta_q  <= {8'd0, fixed_step_q};
        o_scaled_steps_q <= '0;
        o_real_steps_q   <= '0;
      end else begin
        o_fixed_delta_q  <= {8'd0, fixed_step_q};
        o_scaled_steps_q <= qs;
        o_real_steps_q   <= qr;
      end
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.real_delta_ns   = o_real_delta_q;
  assign out_o.scaled_delta_ns = o_scaled_delta_q;
  assign out_o.fixed_delta_ns  = o_fixed_delta_q;
  assign out_o.scaled_steps    = o_scaled_steps_q;
  assign out_o.real_steps      = o_real_steps_q;
  assign out_o.frame_rate      = o_frame_rate_q;

  // The rate divider's remainder is not needed; it only keeps the port connected.
  logic rate_rem_unused;
  assign rate_rem_unused = |rf;

  a_frame_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_acc |=> (state_q == fta_pkg::ST_MUL))
    else $error("frame word did not start the multiply");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q == fta_pkg::ST_DONE))
    else $error("result raised outside the finish state");

  a_no_result_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.operation != fta_pkg::OP_FRAME && !out_o.valid) |=> !out_o.valid)
    else $error("non-frame word produced a result");

  a_rem_below_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && upd) |=> (rem_r_q < fixed_step_q) && (rem_s_q < fixed_step_q))
    else $error("kept remainder not below the fixed step");

endmodule

`default_nettype wire

@@ sv/fta_div.sv @@
// ----------------------------------------------------------------------------
// Fixed-timestep accumulator divider
// Restoring divider that retires one quotient bit per step, with a
// saturating quotient and the exact remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fta_div #(
  parameter int unsigned QUOT_W = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          load_i,
  input  wire logic                          step_i,
  input  wire logic [fta_pkg::SUM_W-1:0]     dividend_i,
  input  wire logic [fta_pkg::REM_W-1:0]     divisor_i,
  output logic      [QUOT_W-1:0]             quot_o,
  output logic      [fta_pkg::REM_W-1:0]     rem_o
);

  logic [fta_pkg::SUM_W-1:0] dvd_q, dvd_d;
  logic [fta_pkg::REM_W-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0]         quot_q, quot_d;
  logic                      ovf_q, ovf_d;
  logic [fta_pkg::REM_W:0]   trial;
  logic [fta_pkg::REM_W+1:0] diff;
  logic                      ge;

  always_comb begin
    trial  = {rem_q, dvd_q[fta_pkg::SUM_W-1]};
    diff   = {1'b0, trial} - {2'b00, divisor_i};
    ge     = !diff[fta_pkg::REM_W+1];
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    ovf_d  = ovf_q;
    if (load_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      quot_d = '0;
      ovf_d  = 1'b0;
    end else if (step_i) begin
      dvd_d  = {dvd_q[fta_pkg::SUM_W-2:0], 1'b0};
      rem_d  = ge ? diff[fta_pkg::REM_W-1:0] : trial[fta_pkg::REM_W-1:0];
      quot_d = {quot_q[QUOT_W-2:0], ge};
      ovf_d  = ovf_q | quot_q[QUOT_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    ovf_q  <= ovf_d;
  end

  assign quot_o = ovf_q ? '1 : quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire
